[sv/cube_face_cell_select_macros.svh]
// ----------------------------------------------------------------------------
// cube_face_cell_select_macros
// Assertion macros for the cube face cell select block. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CUBE_FACE_CELL_SELECT_MACROS_SVH
`define CUBE_FACE_CELL_SELECT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, reset disables
`define CFCS_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfcs assertion failed");
// next-cycle implication, reset disables
`define CFCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfcs assertion failed");
`else
`define CFCS_ASSERT(lbl, clk, rst, ante, cons)
`define CFCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[sv/cfcs_pkg.sv]
// ----------------------------------------------------------------------------
// cfcs_pkg
// Shared types and constants of the cube face cell select block.
// ----------------------------------------------------------------------------
package cfcs_pkg;

   localparam int RES_W  = 13;   // resolution register width
   localparam int FACE_W = 3;

   localparam logic [RES_W-1:0] RES_RESET = 13'd256;

   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

   // control that travels beside the datapath
   typedef struct packed {
      logic              valid;
      logic              zero;
      logic [FACE_W-1:0] face;
   } ctrl_type;

endpackage

[sv/cfcs_face_sel.sv]
// ----------------------------------------------------------------------------
// cfcs_face_sel
// Three stages: magnitudes, major axis and face pick, then the shifted
// numerators n+a and the divisor 2a for both cell lanes.
// ----------------------------------------------------------------------------
module cfcs_face_sel #(
   parameter int COORD_WIDTH = 16,
   parameter int MAX_RES     = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [COORD_WIDTH-1:0]  dir_x,
   input  logic signed [COORD_WIDTH-1:0]  dir_y,
   input  logic signed [COORD_WIDTH-1:0]  dir_z,
   input  logic [cfcs_pkg::RES_W-1:0]     res,
   output cfcs_pkg::ctrl_type             ctrl,
   output logic [cfcs_pkg::RES_W-1:0]     res_out,
   output logic [COORD_WIDTH:0]           num_u,
   output logic [COORD_WIDTH:0]           num_v,
   output logic [COORD_WIDTH:0]           den
);
   import cfcs_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int R_LIM = (MAX_RES < (1 << RES_W)) ? MAX_RES : ((1 << RES_W) - 1);
   localparam logic [RES_W-1:0] R_CAP = R_LIM[RES_W-1:0];

   // ---- stage 1: magnitudes ----
   logic [CW-1:0] ux, uy, uz;
   logic [CW-1:0] ax_in, ay_in, az_in;
   logic          zero_in;
   logic [RES_W-1:0] res_in;

   assign ux = dir_x;
   assign uy = dir_y;
   assign uz = dir_z;
   assign ax_in = ux[CW-1] ? (~ux + CW'(1'b1)) : ux;
   assign ay_in = uy[CW-1] ? (~uy + CW'(1'b1)) : uy;
   assign az_in = uz[CW-1] ? (~uz + CW'(1'b1)) : uz;
   assign zero_in = (ux == '0) && (uy == '0) && (uz == '0);
   assign res_in  = (res > R_CAP) ? R_CAP : res;

   logic                 v1_ff, zero1_ff;
   logic signed [CW-1:0] x1_ff, y1_ff, z1_ff;
   logic [CW-1:0]        ax1_ff, ay1_ff, az1_ff;
   logic [RES_W-1:0]     res1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      zero1_ff <= zero_in;
      x1_ff    <= dir_x;
      y1_ff    <= dir_y;
      z1_ff    <= dir_z;
      ax1_ff   <= ax_in;
      ay1_ff   <= ay_in;
      az1_ff   <= az_in;
      res1_ff  <= res_in;
   end

   // ---- stage 2: major axis, ties go X then Y then Z ----
   logic signed [CW:0] xe, ye, ze, nxe, nze;
   logic               x_major, y_major;
   logic [FACE_W-1:0]  face_in;
   logic [CW-1:0]      a_in;
   logic signed [CW:0] nu_in, nv_in;

   assign xe  = {x1_ff[CW-1], x1_ff};
   assign ye  = {y1_ff[CW-1], y1_ff};
   assign ze  = {z1_ff[CW-1], z1_ff};
   assign nxe = -xe;
   assign nze = -ze;
   assign x_major = (ax1_ff >= ay1_ff) && (ax1_ff >= az1_ff);
   assign y_major = (ay1_ff >= az1_ff);

   always_comb begin
      if (x_major) begin
         a_in    = ax1_ff;
         face_in = x1_ff[CW-1] ? FACE_NEG_X : FACE_POS_X;
         nu_in   = x1_ff[CW-1] ? ze : nze;
         nv_in   = ye;
      end else if (y_major) begin
         a_in    = ay1_ff;
         face_in = y1_ff[CW-1] ? FACE_NEG_Y : FACE_POS_Y;
         nu_in   = xe;
         nv_in   = y1_ff[CW-1] ? ze : nze;
      end else begin
         a_in    = az1_ff;
         face_in = z1_ff[CW-1] ? FACE_NEG_Z : FACE_POS_Z;
         nu_in   = z1_ff[CW-1] ? nxe : xe;
         nv_in   = ye;
      end
   end

   logic               v2_ff, zero2_ff;
   logic [FACE_W-1:0]  face2_ff;
   logic [CW-1:0]      a2_ff;
   logic signed [CW:0] nu2_ff, nv2_ff;
   logic [RES_W-1:0]   res2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      zero2_ff <= zero1_ff;
      face2_ff <= face_in;
      a2_ff    <= a_in;
      nu2_ff   <= nu_in;
      nv2_ff   <= nv_in;
      res2_ff  <= res1_ff;
   end

   // ---- stage 3: n + a lies in 0..2a, kept unsigned ----
   logic signed [CW:0] a_s;
   logic [CW:0]        su_in, sv_in;

   assign a_s   = $signed({1'b0, a2_ff});
   assign su_in = nu2_ff + a_s;
   assign sv_in = nv2_ff + a_s;

   ctrl_type         ctrl3_ff;
   logic [CW:0]      su3_ff, sv3_ff, den3_ff;
   logic [RES_W-1:0] res3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl3_ff.valid <= 1'b0;
      end else begin
         ctrl3_ff.valid <= v2_ff;
      end
      ctrl3_ff.zero <= zero2_ff;
      ctrl3_ff.face <= face2_ff;
      su3_ff        <= su_in;
      sv3_ff        <= sv_in;
      den3_ff       <= {a2_ff, 1'b0};
      res3_ff       <= res2_ff;
   end

   assign ctrl    = ctrl3_ff;
   assign res_out = res3_ff;
   assign num_u   = su3_ff;
   assign num_v   = sv3_ff;
   assign den     = den3_ff;

endmodule

[sv/cfcs_div_lane.sv]
// ----------------------------------------------------------------------------
// cfcs_div_lane
// One cell lane: (n+a)*R, a pipelined restoring divide by 2a with one
// quotient bit per stage, then the clamp to 0..R-1.
// ----------------------------------------------------------------------------
module cfcs_div_lane #(
   parameter int COORD_WIDTH = 16,
   parameter int CELL_WIDTH  = 12
) (
   input  logic                        clock,
   input  logic [COORD_WIDTH:0]        num,
   input  logic [COORD_WIDTH:0]        den,
   input  logic [cfcs_pkg::RES_W-1:0]  res,
   output logic [CELL_WIDTH-1:0]       cell_idx
);
   import cfcs_pkg::*;

   localparam int N_W = COORD_WIDTH + 1;
   localparam int Q_W = RES_W;      // quotient never exceeds R while the divisor is nonzero
   localparam int P_W = N_W + Q_W;

   logic [P_W-1:0]   rem_ff [0:Q_W];
   logic [Q_W-1:0]   quo_ff [0:Q_W];
   logic [N_W-1:0]   den_ff [0:Q_W];
   logic [RES_W-1:0] res_ff [0:Q_W];

   logic [P_W-1:0] prod_in;
   assign prod_in = {{Q_W{1'b0}}, num} * {{N_W{1'b0}}, res};

   always_ff @(posedge clock) begin
      rem_ff[0] <= prod_in;
      quo_ff[0] <= '0;
      den_ff[0] <= den;
      res_ff[0] <= res;
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      localparam int SH = Q_W - 1 - k;
      logic [P_W-1:0] step_d;
      logic           fits;

      assign step_d = {{Q_W{1'b0}}, den_ff[k]} << SH;
      assign fits   = (rem_ff[k] >= step_d);

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= fits ? (rem_ff[k] - step_d) : rem_ff[k];
         quo_ff[k+1] <= {quo_ff[k][Q_W-2:0], fits};
         den_ff[k+1] <= den_ff[k];
         res_ff[k+1] <= res_ff[k];
      end
   end

   // clamp; zero resolution gives zero
   logic [RES_W-1:0]          res_last, lim;
   logic [Q_W-1:0]            clamped;
   logic [Q_W+CELL_WIDTH-1:0] ext;
   logic [CELL_WIDTH-1:0]     cell_ff;

   assign res_last = res_ff[Q_W];
   assign lim      = res_last - RES_W'(1'b1);

   always_comb begin
      if (res_last == '0) begin
         clamped = '0;
      end else if (quo_ff[Q_W] > lim) begin
         clamped = lim;
      end else begin
         clamped = quo_ff[Q_W];
      end
   end

   assign ext = {{CELL_WIDTH{1'b0}}, clamped};

   always_ff @(posedge clock) begin
      cell_ff <= ext[CELL_WIDTH-1:0];
   end

   assign cell_idx = cell_ff;

endmodule

[sv/cube_face_cell_select.sv]
// ----------------------------------------------------------------------------
// cube_face_cell_select
// Direction vector to cube face and cell indices on a face grid.
// ----------------------------------------------------------------------------
// Usage:
//   Request: a word (req_dir_x/y/z) is taken at each rising edge with start
//   high and busy low. busy is high only during reset; otherwise a new word
//   can be taken every cycle.
//   Response: each request gives one response word, shown for one cycle
//   with rsp_valid high. The receiver cannot hold it off.
//   Path: face selection, then in each cell lane the multiply, a restoring
//   divide with one quotient bit per stage of the 13-bit resolution, and
//   the clamp; then the output register. Throughput: one word per cycle.
//   csr: face_resolution is written when csr_valid and csr_ready are high.
//   It is sampled as a word enters, so a write affects later words only.
//   Values above MAX_RES act as MAX_RES.
//   Reset: synchronous; clears all valid bits, loads resolution 256, and
//   holds busy high and csr_ready low while asserted.
// ----------------------------------------------------------------------------
`include "cube_face_cell_select_macros.svh"

module cube_face_cell_select #(
   parameter int COORD_WIDTH = 16,
   parameter int MAX_RES     = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   // request
   input  logic                             start,
   output logic                             busy,
   input  logic signed [COORD_WIDTH-1:0]    req_dir_x,
   input  logic signed [COORD_WIDTH-1:0]    req_dir_y,
   input  logic signed [COORD_WIDTH-1:0]    req_dir_z,
   // response
   output logic                             rsp_valid,
   output logic [cfcs_pkg::FACE_W-1:0]      rsp_face,
   output logic [$clog2(MAX_RES)-1:0]       rsp_u_cell,
   output logic [$clog2(MAX_RES)-1:0]       rsp_v_cell,
   output logic                             rsp_zero_dir,
   // csr
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cfcs_pkg::RES_W-1:0]       csr_face_resolution
);
   import cfcs_pkg::*;

   localparam int CELL_W   = $clog2(MAX_RES);
   localparam int LANE_LAT = RES_W + 2;          // multiply, divide bits, clamp
   localparam int PIPE_LAT = 3 + LANE_LAT + 1;   // face stages, lanes, output

   // pipeline never stalls; only reset holds off words
   assign busy      = reset;
   assign csr_ready = !reset;

   logic req_accept;
   assign req_accept = start && !busy;

   // resolution register
   logic [RES_W-1:0] res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= RES_RESET;
      end else if (csr_valid && csr_ready) begin
         res_ff <= csr_face_resolution;
      end
   end

   // face selection, three stages
   ctrl_type             sel_ctrl;
   logic [RES_W-1:0]     sel_res;
   logic [COORD_WIDTH:0] sel_num_u, sel_num_v, sel_den;

   cfcs_face_sel #(
      .COORD_WIDTH (COORD_WIDTH),
      .MAX_RES     (MAX_RES)
   ) u_face_sel (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_accept),
      .dir_x    (req_dir_x),
      .dir_y    (req_dir_y),
      .dir_z    (req_dir_z),
      .res      (res_ff),
      .ctrl     (sel_ctrl),
      .res_out  (sel_res),
      .num_u    (sel_num_u),
      .num_v    (sel_num_v),
      .den      (sel_den)
   );

   // u and v lanes share the divisor
   logic [CELL_W-1:0] lane_u, lane_v;

   cfcs_div_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .CELL_WIDTH  (CELL_W)
   ) u_lane_u (
      .clock    (clock),
      .num      (sel_num_u),
      .den      (sel_den),
      .res      (sel_res),
      .cell_idx (lane_u)
   );

   cfcs_div_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .CELL_WIDTH  (CELL_W)
   ) u_lane_v (
      .clock    (clock),
      .num      (sel_num_v),
      .den      (sel_den),
      .res      (sel_res),
      .cell_idx (lane_v)
   );

   // control rides alongside the lanes
   ctrl_type ctrl_ff [0:LANE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) begin
            ctrl_ff[i] <= '0;
         end
      end else begin
         ctrl_ff[0] <= sel_ctrl;
         for (int i = 1; i < LANE_LAT; i++) begin
            ctrl_ff[i] <= ctrl_ff[i-1];
         end
      end
   end

   // output register; a zero vector forces the cells to zero
   ctrl_type          last_ctrl;
   logic              rsp_valid_ff, zero_ff;
   logic [FACE_W-1:0] face_ff;
   logic [CELL_W-1:0] u_ff, v_ff;
   logic [CELL_W-1:0] u_in, v_in;

   assign last_ctrl = ctrl_ff[LANE_LAT-1];
   assign u_in      = last_ctrl.zero ? '0 : lane_u;
   assign v_in      = last_ctrl.zero ? '0 : lane_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last_ctrl.valid;
      end
      zero_ff <= last_ctrl.zero;
      face_ff <= last_ctrl.face;
      u_ff    <= u_in;
      v_ff    <= v_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_face     = face_ff;
   assign rsp_u_cell   = u_ff;
   assign rsp_v_cell   = v_ff;
   assign rsp_zero_dir = zero_ff;

   // every accepted word comes out a fixed time later, nothing else does
   `CFCS_ASSERT(a_rsp_latency, clock, reset, req_accept, ##PIPE_LAT rsp_valid)
   `CFCS_ASSERT(a_no_extra_rsp, clock, reset, !req_accept, ##PIPE_LAT !rsp_valid)
   `CFCS_ASSERT(a_zero_dir, clock, reset, rsp_valid && rsp_zero_dir, rsp_face == FACE_POS_X && rsp_u_cell == '0 && rsp_v_cell == '0)
   `CFCS_ASSERT_NEXT(a_csr_write, clock, reset, csr_valid && csr_ready, res_ff == $past(csr_face_resolution))

endmodule
